FILE: hw/rtl/elt_pkg.sv
// Package for the exclusive lock table: sizes, command and status codes,
// beat structs and the controller/datapath interface structs.
// No dependencies.
package elt_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int TXN_WIDTH   = 16;
  localparam int SLOT_IDX_W  = $clog2(TABLE_SLOTS);
  localparam int FREED_W     = 7;

  localparam logic [FREED_W-1:0] FREED_MAX = {FREED_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ACQUIRE     = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_ALL = 2'd2,
    CMD_QUERY       = 2'd3
  } elt_cmd_e;

  typedef enum logic [2:0] {
    STAT_GRANTED   = 3'd0,
    STAT_CONFLICT  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_RELEASED  = 3'd3,
    STAT_NOT_OWNER = 3'd4,
    STAT_DONE      = 3'd5
  } elt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } elt_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] lock_key;
    logic [15:0] transaction;
  } elt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        owns;
    logic [15:0] current_owner;
    logic [6:0]  freed_count;
  } elt_out_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } elt_ctrl_t;

  typedef struct packed {
    logic issue_last;
    logic out_free;
  } elt_stat_t;

endpackage

FILE: hw/rtl/elt_ctrl.sv
// Controller of the exclusive lock table: sequences accept, table scan,
// drain and commit. Depends on elt_pkg.
module elt_ctrl import elt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  elt_stat_t stat_i,
  output elt_ctrl_t ctrl_o
);

  elt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ctrl_o     = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.issue = 1'b1;
        if (stat_i.issue_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/elt_datapath.sv
// Datapath of the exclusive lock table: slot memory, used bits, scan
// pipeline, match trackers and the result register. Depends on elt_pkg.
module elt_datapath import elt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  elt_in_t   in_data_i,
  input  elt_ctrl_t ctrl_i,
  output elt_stat_t stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output elt_out_t  out_data_o
);

  logic [KEY_WIDTH-1:0] key_mem [TABLE_SLOTS];
  logic [TXN_WIDTH-1:0] own_mem [TABLE_SLOTS];

  logic [TABLE_SLOTS-1:0] used_q, used_d;
  logic [1:0]             cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [TXN_WIDTH-1:0]   txn_q;
  logic [SLOT_IDX_W-1:0]  addr_q;
  logic                   rd_vld_q;
  logic [SLOT_IDX_W-1:0]  rd_idx_q;
  logic [KEY_WIDTH-1:0]   rd_key_q;
  logic [TXN_WIDTH-1:0]   rd_own_q;
  logic                   found_q;
  logic [SLOT_IDX_W-1:0]  found_idx_q;
  logic [TXN_WIDTH-1:0]   found_own_q;
  logic                   free_q;
  logic [SLOT_IDX_W-1:0]  free_idx_q;
  logic [FREED_W-1:0]     freed_q;
  logic                   out_valid_q;
  elt_out_t               out_q, res_d;

  logic rd_used, rd_hit, rd_mine, fnd_mine, mem_we;

  assign rd_used  = used_q[rd_idx_q];
  assign rd_hit   = rd_vld_q && rd_used && (rd_key_q == key_q);
  assign rd_mine  = rd_own_q == txn_q;
  assign fnd_mine = found_q && (found_own_q == txn_q);

  assign stat_o.issue_last = addr_q == SLOT_IDX_W'(TABLE_SLOTS - 1);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    used_d = used_q;
    mem_we = 1'b0;
    res_d  = '0;
    res_d.status = STAT_DONE;
    if (rd_vld_q && rd_used && rd_mine && cmd_q == CMD_RELEASE_ALL) begin
      used_d[rd_idx_q] = 1'b0;
    end
    if (ctrl_i.commit) begin
      case (cmd_q)
        CMD_ACQUIRE: begin
          if (found_q) begin
            if (fnd_mine) begin
              res_d.status = STAT_GRANTED;
            end else begin
              res_d.status        = STAT_CONFLICT;
              res_d.current_owner = 16'(found_own_q);
            end
          end else if (free_q) begin
            mem_we             = 1'b1;
            used_d[free_idx_q] = 1'b1;
            res_d.status       = STAT_GRANTED;
          end else begin
            res_d.status = STAT_FULL;
          end
        end
        CMD_RELEASE: begin
          if (fnd_mine) begin
            used_d[found_idx_q] = 1'b0;
            res_d.status        = STAT_RELEASED;
          end else begin
            res_d.status = STAT_NOT_OWNER;
          end
        end
        CMD_RELEASE_ALL: begin
          res_d.freed_count = freed_q;
        end
        default: begin
          res_d.owns = fnd_mine;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      rd_key_q <= key_mem[addr_q];
      rd_own_q <= own_mem[addr_q];
    end
    if (mem_we) begin
      key_mem[free_idx_q] <= key_q;
      own_mem[free_idx_q] <= txn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q   <= used_d;
      rd_vld_q <= ctrl_i.issue;
      if (ctrl_i.load) begin
        addr_q <= '0;
      end else if (ctrl_i.issue) begin
        addr_q <= addr_q + 1'b1;
      end
      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      rd_idx_q <= addr_q;
    end
    if (ctrl_i.load) begin
      cmd_q   <= in_data_i.command;
      key_q   <= in_data_i.lock_key[KEY_WIDTH-1:0];
      txn_q   <= in_data_i.transaction[TXN_WIDTH-1:0];
      found_q <= 1'b0;
      free_q  <= 1'b0;
      freed_q <= '0;
    end else if (rd_vld_q) begin
      if (rd_hit) begin
        found_q     <= 1'b1;
        found_idx_q <= rd_idx_q;
        found_own_q <= rd_own_q;
      end
      if (!rd_used && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (rd_used && rd_mine && cmd_q == CMD_RELEASE_ALL && freed_q != FREED_MAX) begin
        freed_q <= freed_q + 1'b1;
      end
    end
    if (ctrl_i.commit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/exclusive_lock_table.sv
// Exclusive lock table: one owning transaction per key, with acquire,
// release, release-all and query commands. Each accepted beat scans the
// whole slot memory through its single read port, one slot per cycle. An
// item is accepted, then every slot is read, the read pipeline is drained
// and the result is committed to the output register once that is free.
// The next beat is accepted while a result still waits in the output
// register. A new key takes the lowest free slot; a full table answers
// table-full. No clearing pass follows reset.
// Top level; depends on elt_pkg, elt_ctrl and elt_datapath.
module exclusive_lock_table import elt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  elt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output elt_out_t out_data_o
);

  elt_ctrl_t ctrl;
  elt_stat_t stat;

  elt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  elt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
